/* rtl/bpm_pkg.sv */
// Package for the bracket pair matcher: token class and status codes,
// fixed field widths. No dependencies.

package bpm_pkg;

	localparam int CLASS_W  = 3;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;

	typedef enum logic [CLASS_W-1:0] {
		TC_OTHER = 3'd0,
		TC_OPEN  = 3'd1,
		TC_CLOSE = 3'd2,
		TC_STMT  = 3'd3,
		TC_END   = 3'd4
	} token_class_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 3'd0,
		ST_MISSING_LEFT  = 3'd1,
		ST_MISMATCH      = 3'd2,
		ST_MISSING_RIGHT = 3'd3,
		ST_OVERFLOW      = 3'd4
	} status_t;

endpackage

/* rtl/bpm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module bpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/bracket_pair_matcher.sv */
// Bracket pair matcher top level: position counter, top-of-stack registers,
// stack RAM and output register. Depends on bpm_pkg and bpm_ram.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid / in_stall  | token_class, bracket_kind
//  out     | out_valid / out_stall| pair_valid, open_position, close_position,
//          |                      | statement_pair, status
//
// One word in, one word out, one word per cycle while in_stall is low; every
// word is finished in the cycle it is accepted and lands in the output register.
// The stack RAM (one write and one registered read per cycle) sets that figure.
// in_stall rises only while a result sits in the output register and out_stall
// is high. After reset the stack is empty and level zero is a statement level;
// no clearing pass runs, so words are taken from the first cycle.

module bracket_pair_matcher
	import bpm_pkg::*;
#(
	parameter int STACK_DEPTH   = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CLASS_W-1:0]       token_class,
	input  logic [KIND_W-1:0]        bracket_kind,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     pair_valid,
	output logic [POSITION_BITS-1:0] open_position,
	output logic [POSITION_BITS-1:0] close_position,
	output logic                     statement_pair,
	output logic [STATUS_W-1:0]      status
);

	localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	// RAM entry i: position and kind of open bracket i, plus the statement
	// flag of the level that bracket i was opened in (level i).
	localparam int EW  = POSITION_BITS + KIND_W + 1;

	// Stack state. The RAM holds every pushed entry; the top entry and the
	// flag of the innermost level are mirrored in registers so that a close
	// resolves without a RAM read. The RAM is always read at the entry just
	// below the top the next word will see, so a pop finds its new top in
	// rdata. Writes go to index sp and only on a push, which reads sp-1:
	// never the same entry in one cycle, so no forwarding is needed.
	logic [SPW-1:0]           sp_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] top_pos_q;
	logic [KIND_W-1:0]        top_kind_q;
	logic                     top_flag_q;
	logic                     cur_flag_q;

	logic                     out_valid_q;
	logic                     pair_valid_q;
	logic [POSITION_BITS-1:0] open_pos_q;
	logic [POSITION_BITS-1:0] close_pos_q;
	logic                     stmt_q;
	status_t                  status_q;

	logic                     accept;
	token_class_t             cls;
	logic                     full;
	logic                     empty;

	logic [SPW-1:0]           sp_next;
	logic [SPW-1:0]           rd_sp;
	logic [POSITION_BITS-1:0] pos_next;
	logic [POSITION_BITS-1:0] top_pos_next;
	logic [KIND_W-1:0]        top_kind_next;
	logic                     top_flag_next;
	logic                     cur_flag_next;

	logic                     ram_we;
	logic [EW-1:0]            ram_wdata;
	logic [AW-1:0]            ram_raddr;
	logic [EW-1:0]            ram_rdata;

	logic                     res_pair;
	logic                     res_stmt;
	logic [POSITION_BITS-1:0] res_open;
	status_t                  res_status;

	// Hold the input while a finished word waits downstream.
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign full  = (sp_q == SPW'(STACK_DEPTH));
	assign empty = (sp_q == '0);

	always_comb begin
		cls            = token_class_t'(token_class);
		sp_next        = sp_q;
		pos_next       = pos_q;
		top_pos_next   = top_pos_q;
		top_kind_next  = top_kind_q;
		top_flag_next  = top_flag_q;
		cur_flag_next  = cur_flag_q;
		ram_we         = 1'b0;
		ram_wdata      = {pos_q, bracket_kind, cur_flag_q};
		res_pair       = 1'b0;
		res_stmt       = 1'b0;
		res_open       = '0;
		res_status     = ST_OK;

		if (accept) begin
			pos_next = pos_q + POSITION_BITS'(1);
			unique case (cls)
				TC_OPEN: begin
					if (full) begin
						// Drop the bracket.
						res_status = ST_OVERFLOW;
					end else begin
						ram_we        = 1'b1;
						top_pos_next  = pos_q;
						top_kind_next = bracket_kind;
						top_flag_next = cur_flag_q;
						cur_flag_next = 1'b0;
						sp_next       = sp_q + SPW'(1);
					end
				end
				TC_CLOSE: begin
					if (empty) begin
						res_status = ST_MISSING_LEFT;
					end else if (top_kind_q != bracket_kind) begin
						// Leave the stack alone.
						res_status = ST_MISMATCH;
					end else begin
						res_pair      = 1'b1;
						res_open      = top_pos_q;
						res_stmt      = cur_flag_q;
						// Statement pair marks the enclosing level.
						cur_flag_next = top_flag_q | cur_flag_q;
						top_pos_next  = ram_rdata[EW-1 -: POSITION_BITS];
						top_kind_next = ram_rdata[KIND_W:1];
						top_flag_next = ram_rdata[0];
						sp_next       = sp_q - SPW'(1);
					end
				end
				TC_STMT: begin
					cur_flag_next = 1'b1;
				end
				TC_END: begin
					if (!empty) begin
						res_status = ST_MISSING_RIGHT;
					end
					sp_next       = '0;
					cur_flag_next = 1'b1;
					pos_next      = '0;
				end
				default: begin
					// Other tokens, and unused class codes, only advance the count.
				end
			endcase
		end

		rd_sp     = sp_next - SPW'(2);
		ram_raddr = rd_sp[AW-1:0];
	end

	bpm_ram #(
		.WIDTH (EW),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sp_q[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			pos_q       <= '0;
			cur_flag_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			sp_q       <= sp_next;
			pos_q      <= pos_next;
			cur_flag_q <= cur_flag_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Top-of-stack mirror and result word: payload, no reset.
	always_ff @(posedge clk) begin
		top_pos_q  <= top_pos_next;
		top_kind_q <= top_kind_next;
		top_flag_q <= top_flag_next;
		if (accept) begin
			pair_valid_q <= res_pair;
			open_pos_q   <= res_open;
			close_pos_q  <= pos_q;
			stmt_q       <= res_stmt;
			status_q     <= res_status;
		end
	end

	assign out_valid      = out_valid_q;
	assign pair_valid     = pair_valid_q;
	assign open_position  = open_pos_q;
	assign close_position = close_pos_q;
	assign statement_pair = stmt_q;
	assign status         = status_q;

endmodule
